// ===== rtl/dccrx_pkg.sv =====
// Shared types and constants for the DCC packet bit receiver.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package dccrx_pkg;

    // Receiver phases
    localparam logic [1:0] PH_PREAMBLE = 2'd0;
    localparam logic [1:0] PH_ADDRESS  = 2'd1;
    localparam logic [1:0] PH_BYTE     = 2'd2;
    localparam logic [1:0] PH_END      = 2'd3;

    localparam int unsigned BIT_COUNT_W = 5;
    localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_MAX = 5'd31;
    localparam logic [BIT_COUNT_W-1:0] BYTE_BITS     = 5'd8;

    localparam int unsigned PREAMBLE_W = 5;
    localparam logic [PREAMBLE_W-1:0] MIN_PREAMBLE_RESET = 5'd10;

    // Register index taken from paddr[2]
    localparam logic REG_MIN_PREAMBLE = 1'b0;

    localparam int unsigned INDEX_W = 3;

    typedef struct packed {
        logic [7:0]         value;
        logic [INDEX_W-1:0] index;
        logic               last;
    } byte_item_t;

endpackage
`default_nettype wire

// ===== rtl/dcc_packet_bit_receiver.sv =====
// DCC packet bit receiver, top level.
// Input channel (bit_valid, bit_stall, line_level): one sampled track bit per
// transfer, where a line level of 1 stands for a 0 bit.
// Output channel (byte_valid, byte_stall, byte_value, byte_index, last_byte):
// the payload bytes of each packet whose XOR check byte matches, address
// byte first, last_byte set on the final one. Failed or over-long packets
// give nothing.
// A bit is taken whenever bit_stall is low. The bit after the end bit of a
// good packet starts the byte sequencer, which reads the packet store one
// entry a cycle while the queue has room; bit_stall stays high until the
// last payload byte has gone into the queue. The first byte passes from the
// store through the queue into the output register, which drives the output.
// When byte_stall is held, the output register and the queue fill, the
// sequencer waits and bit_stall stays high until room frees up.
// Reset clears the phase and counters, empties the queue and sets
// min_preamble_bits to 10. The APB register at address 0 holds
// min_preamble_bits; pready is always high.
// Depends on dccrx_pkg, dccrx_front, dccrx_queue and dccrx_back.
`default_nettype none
module dcc_packet_bit_receiver
    import dccrx_pkg::*;
#(
    parameter int PACKET_BYTES = 6,
    parameter int QUEUE_DEPTH  = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              bit_valid,
    output logic                   bit_stall,
    input  wire logic              line_level,
    output logic                   byte_valid,
    input  wire logic              byte_stall,
    output logic      [7:0]        byte_value,
    output logic      [INDEX_W-1:0] byte_index,
    output logic                   last_byte
);

    logic [PREAMBLE_W-1:0] min_preamble_reg;
    logic                  reg_sel;
    byte_item_t            push_item;
    byte_item_t            pop_item;
    logic                  push_valid;
    logic                  queue_full;
    logic                  queue_empty;
    logic                  queue_pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_MIN_PREAMBLE);
    assign prdata  = reg_sel ? {{(32-PREAMBLE_W){1'b0}}, min_preamble_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_preamble_reg <= MIN_PREAMBLE_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            min_preamble_reg <= pwdata[PREAMBLE_W-1:0];
        end
    end

    dccrx_front #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .min_preamble_bits(min_preamble_reg),
        .bit_valid        (bit_valid),
        .bit_stall        (bit_stall),
        .line_level       (line_level),
        .push_valid       (push_valid),
        .push_item        (push_item),
        .queue_full       (queue_full)
    );

    dccrx_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_item(push_item),
        .full     (queue_full),
        .pop      (queue_pop),
        .pop_item (pop_item),
        .empty    (queue_empty)
    );

    dccrx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_empty(queue_empty),
        .queue_item (pop_item),
        .queue_pop  (queue_pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_value (byte_value),
        .byte_index (byte_index),
        .last_byte  (last_byte)
    );

endmodule
`default_nettype wire

// ===== rtl/dccrx_front.sv =====
// Front part: decodes track bits, assembles packet bytes and checks the XOR byte.
// On a good packet it walks the byte store and pushes items into the queue.
// Depends on dccrx_pkg.
`default_nettype none
module dccrx_front
    import dccrx_pkg::*;
#(
    parameter int PACKET_BYTES = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [PREAMBLE_W-1:0] min_preamble_bits,
    input  wire logic                  bit_valid,
    output logic                       bit_stall,
    input  wire logic                  line_level,
    output logic                       push_valid,
    output byte_item_t                 push_item,
    input  wire logic                  queue_full
);

    localparam int BCW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam logic [BCW:0] PB_W = (BCW+1)'(PACKET_BYTES);

    logic [1:0]             phase_reg, phase_next;
    logic [BIT_COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [BCW-1:0]         byte_count_reg, byte_count_next;
    logic [7:0]             cur_reg, cur_next;
    logic [7:0]             chk_reg, chk_next;
    logic                   pass_reg, pass_next;
    logic                   seq_active_reg, seq_active_next;
    logic [BCW-1:0]         seq_idx_reg, seq_idx_next;
    logic [BCW-1:0]         seq_cnt_reg, seq_cnt_next;

    logic [7:0]             store_reg [PACKET_BYTES];
    logic                   store_we;

    logic accept;
    logic bitval;
    logic seq_last;
    logic push_fire;

    assign bit_stall = seq_active_reg;
    assign accept    = bit_valid && !seq_active_reg;
    assign bitval    = ~line_level;

    assign seq_last   = ({1'b0, seq_idx_reg} + 1'b1) == {1'b0, seq_cnt_reg};
    assign push_valid = seq_active_reg;
    assign push_fire  = seq_active_reg && !queue_full;

    always_comb
    begin
        push_item.value = store_reg[seq_idx_reg];
        push_item.index = INDEX_W'(seq_idx_reg);
        push_item.last  = seq_last;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        cur_next        = cur_reg;
        chk_next        = chk_reg;
        pass_next       = pass_reg;
        seq_active_next = seq_active_reg;
        seq_idx_next    = seq_idx_reg;
        seq_cnt_next    = seq_cnt_reg;
        store_we        = 1'b0;

        if (push_fire)
        begin
            seq_idx_next = seq_idx_reg + 1'b1;
            if (seq_last)
            begin
                seq_active_next = 1'b0;
            end
        end

        if (accept)
        begin
            case (phase_reg)
                PH_PREAMBLE:
                begin
                    if (bitval)
                    begin
                        if (bit_count_reg < BIT_COUNT_MAX)
                        begin
                            bit_count_next = bit_count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (bit_count_reg >= min_preamble_bits)
                        begin
                            phase_next = PH_ADDRESS;
                        end
                        bit_count_next = '0;
                    end
                end
                PH_ADDRESS:
                begin
                    if (bit_count_reg < BYTE_BITS)
                    begin
                        cur_next       = {cur_reg[6:0], bitval};
                        bit_count_next = bit_count_reg + 1'b1;
                    end
                    else
                    begin
                        store_we = 1'b1;
                        // Entry 0 is the address byte; a repeated address byte
                        // lands in entry 1 and leaves the running XOR alone.
                        if (byte_count_reg == '0)
                        begin
                            chk_next = cur_reg;
                        end
                        bit_count_next  = '0;
                        byte_count_next = BCW'(1);
                        if (!bitval)
                        begin
                            phase_next = PH_BYTE;
                        end
                    end
                end
                PH_BYTE:
                begin
                    if (bit_count_reg < BYTE_BITS)
                    begin
                        cur_next       = {cur_reg[6:0], bitval};
                        bit_count_next = bit_count_reg + 1'b1;
                    end
                    else
                    begin
                        store_we       = 1'b1;
                        bit_count_next = '0;
                        if (bitval)
                        begin
                            phase_next = PH_END;
                            pass_next  = (chk_reg == cur_reg);
                        end
                        else if (({1'b0, byte_count_reg} + 1'b1) < PB_W)
                        begin
                            byte_count_next = byte_count_reg + 1'b1;
                            chk_next        = chk_reg ^ cur_reg;
                        end
                        else
                        begin
                            // Packet too long: drop it.
                            byte_count_next = '0;
                            phase_next      = PH_PREAMBLE;
                        end
                    end
                end
                default:
                begin
                    if (pass_reg)
                    begin
                        seq_active_next = 1'b1;
                        seq_idx_next    = '0;
                        seq_cnt_next    = byte_count_reg;
                    end
                    phase_next      = PH_PREAMBLE;
                    bit_count_next  = '0;
                    byte_count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PREAMBLE;
            bit_count_reg  <= '0;
            byte_count_reg <= '0;
            pass_reg       <= 1'b0;
            seq_active_reg <= 1'b0;
            seq_idx_reg    <= '0;
            seq_cnt_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            pass_reg       <= pass_next;
            seq_active_reg <= seq_active_next;
            seq_idx_reg    <= seq_idx_next;
            seq_cnt_reg    <= seq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        chk_reg <= chk_next;
        if (store_we)
        begin
            store_reg[byte_count_reg] <= cur_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dccrx_queue.sv =====
// Short queue of byte items between the front and back parts.
// Depends on dccrx_pkg.
`default_nettype none
module dccrx_queue
    import dccrx_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire byte_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output byte_item_t      pop_item,
    output logic            empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    byte_item_t     slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dccrx_back.sv =====
// Back part: output register that presents byte items to the receiver.
// Depends on dccrx_pkg.
`default_nettype none
module dccrx_back
    import dccrx_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          queue_empty,
    input  wire byte_item_t    queue_item,
    output logic               queue_pop,
    output logic               byte_valid,
    input  wire logic          byte_stall,
    output logic [7:0]         byte_value,
    output logic [INDEX_W-1:0] byte_index,
    output logic               last_byte
);

    logic       out_valid_reg, out_valid_next;
    byte_item_t out_item_reg;
    logic       load;

    // The register refills whenever the queue holds an item and the register is empty or its transfer completes.
    assign load      = !queue_empty && (!out_valid_reg || !byte_stall);
    assign queue_pop = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!byte_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= queue_item;
        end
    end

    assign byte_valid = out_valid_reg;
    assign byte_value = out_item_reg.value;
    assign byte_index = out_item_reg.index;
    assign last_byte  = out_item_reg.last;

endmodule
`default_nettype wire
